FILE: src/tcss_pkg.sv
package tcss_pkg;

    // Operation codes of a request
    typedef enum logic [2:0] {
        OP_SEC_TICK  = 3'd0,
        OP_SCAN_TICK = 3'd1,
        OP_SET_HM    = 3'd2,
        OP_ADD_HM    = 3'd3,
        OP_SET_LOW   = 3'd4,
        OP_ADD_LOW   = 3'd5,
        OP_READ      = 3'd6
    } op_t;

    // Three base-60 time fields
    typedef struct packed {
        logic [5:0] high;
        logic [5:0] mid;
        logic [5:0] low;
    } time_t;

    // Quotient and remainder of a division by 60
    typedef struct packed {
        logic [1:0] q;
        logic [5:0] r;
    } div60_t;

    localparam logic [7:0] BASE60       = 8'd60;
    localparam logic [7:0] DASH_PATTERN = 8'h40;

    localparam logic [7:0] SEG_TABLE [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    // Divide a value below 240 by 60 with three compares
    function automatic div60_t div60(input logic [7:0] x);
        div60_t     res;
        logic [7:0] rem;
        if (x >= 8'd180)
        begin
            res.q = 2'd3;
            rem   = x - 8'd180;
        end
        else if (x >= 8'd120)
        begin
            res.q = 2'd2;
            rem   = x - 8'd120;
        end
        else if (x >= BASE60)
        begin
            res.q = 2'd1;
            rem   = x - BASE60;
        end
        else
        begin
            res.q = 2'd0;
            rem   = x;
        end
        res.r = rem[5:0];
        return res;
    endfunction

endpackage

FILE: src/tcss_if.sv
// Request channel: one event or command
interface tcss_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [6:0] value_high;
    logic [6:0] value_low;

    modport source (output valid, output operation, output value_high,
                    output value_low, input ready);
    modport sink   (input valid, input operation, input value_high,
                    input value_low, output ready);
endinterface

// Result channel: display drive and time fields
interface tcss_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] segment_pattern;
    logic [7:0] digit_select;
    logic [5:0] field_high;
    logic [5:0] field_mid;
    logic [5:0] field_low;

    modport source (output valid, output segment_pattern, output digit_select,
                    output field_high, output field_mid, output field_low,
                    input ready);
    modport sink   (input valid, input segment_pattern, input digit_select,
                    input field_high, input field_mid, input field_low,
                    output ready);
endinterface

FILE: src/tcss_norm.sv
// Applies one operation to the time and normalizes the three fields
module tcss_norm (
    input  tcss_pkg::op_t   op,
    input  logic [6:0]      value_high,
    input  logic [6:0]      value_low,
    input  tcss_pkg::time_t cur,
    output tcss_pkg::time_t nxt
);

    logic [7:0]       lo_sum;
    logic [7:0]       mi_base;
    logic [7:0]       hi_base;
    logic [7:0]       mi_sum;
    logic [7:0]       hi_sum;
    tcss_pkg::div60_t lo_div;
    tcss_pkg::div60_t mi_div;
    tcss_pkg::div60_t hi_div;

    // Raw field values after the operation, all below 190
    always_comb
    begin
        lo_sum  = {2'b00, cur.low};
        mi_base = {2'b00, cur.mid};
        hi_base = {2'b00, cur.high};
        case (op)
            tcss_pkg::OP_SEC_TICK: lo_sum = {2'b00, cur.low} + 8'd1;
            tcss_pkg::OP_SET_LOW:  lo_sum = {1'b0, value_high};
            tcss_pkg::OP_ADD_LOW:  lo_sum = {2'b00, cur.low} + {1'b0, value_high};
            tcss_pkg::OP_SET_HM:
            begin
                hi_base = {1'b0, value_high};
                mi_base = {1'b0, value_low};
            end
            tcss_pkg::OP_ADD_HM:
            begin
                hi_base = {2'b00, cur.high} + {1'b0, value_high};
                mi_base = {2'b00, cur.mid} + {1'b0, value_low};
            end
            default: ;
        endcase
    end

    // Carry chain low -> mid -> high, high wraps mod 60
    always_comb
    begin
        lo_div   = tcss_pkg::div60(lo_sum);
        mi_sum   = mi_base + {6'd0, lo_div.q};
        mi_div   = tcss_pkg::div60(mi_sum);
        hi_sum   = hi_base + {6'd0, mi_div.q};
        hi_div   = tcss_pkg::div60(hi_sum);
        nxt.low  = lo_div.r;
        nxt.mid  = mi_div.r;
        nxt.high = hi_div.r;
    end

endmodule

FILE: src/tcss_disp.sv
// Segment pattern and digit enable for one scan position
module tcss_disp (
    input  logic [2:0]      pos,
    input  tcss_pkg::time_t tm,
    output logic [7:0]      segment_pattern,
    output logic [7:0]      digit_select
);

    logic [5:0] field;
    logic [3:0] tens;
    logic [5:0] tens_x10;
    logic [5:0] units;

    // Pick the field that this position shows
    always_comb
    begin
        case (pos)
            3'd0, 3'd1: field = tm.high;
            3'd3, 3'd4: field = tm.mid;
            default:    field = tm.low;
        endcase
    end

    // Decimal split of a value below 60
    always_comb
    begin
        if (field >= 6'd50)
            tens = 4'd5;
        else if (field >= 6'd40)
            tens = 4'd4;
        else if (field >= 6'd30)
            tens = 4'd3;
        else if (field >= 6'd20)
            tens = 4'd2;
        else if (field >= 6'd10)
            tens = 4'd1;
        else
            tens = 4'd0;
        tens_x10 = {tens[2:0], 3'b000} + {1'b0, tens[3:0], 1'b0};
        units    = field - tens_x10;
    end

    // Tens on the first digit of a pair, units on the second, dashes between pairs
    always_comb
    begin
        case (pos)
            3'd0, 3'd3, 3'd6: segment_pattern = tcss_pkg::SEG_TABLE[tens];
            3'd1, 3'd4, 3'd7: segment_pattern = tcss_pkg::SEG_TABLE[units[3:0]];
            default:          segment_pattern = tcss_pkg::DASH_PATTERN;
        endcase
        digit_select = 8'd1 << pos;
    end

endmodule

FILE: src/time_counter_seven_segment_scan.sv
// Digital clock with an eight-digit multiplexed seven-segment scan. Each
// request (second tick, scan tick, set/add to high+mid or to low, read)
// yields exactly one result holding the digit pattern and one-hot enable for
// the scanned position, plus the three normalized base-60 fields. The block
// is a two-register pipeline: a request register, then field update, carry
// normalization and digit decode into the result register. It takes one
// request per cycle while the result side drains; a request moves from the
// request register into the result register when the result register is
// free or being read. While a result waits unread, the pipeline holds and
// request ready drops once the request register is also full. A scan tick
// shows the position it drives, then advances.
module time_counter_seven_segment_scan (
    input logic          clk,
    input logic          rst_n,
    tcss_req_if.sink     req,
    tcss_rsp_if.source   rsp
);

    logic            in_valid_reg;
    tcss_pkg::op_t   op_reg;
    logic [6:0]      vh_reg;
    logic [6:0]      vl_reg;
    tcss_pkg::time_t time_reg;
    tcss_pkg::time_t time_next;
    logic [2:0]      scan_reg;
    logic [2:0]      scan_next;
    logic            advance;
    logic            out_valid_reg;
    logic [7:0]      seg_reg;
    logic [7:0]      sel_reg;
    tcss_pkg::time_t res_reg;
    logic [7:0]      seg_next;
    logic [7:0]      sel_next;

    // Pipeline moves when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg <= tcss_pkg::op_t'(req.operation);
            vh_reg <= req.value_high;
            vl_reg <= req.value_low;
        end
    end

    // Field update and normalization
    tcss_norm u_norm (
        .op         (op_reg),
        .value_high (vh_reg),
        .value_low  (vl_reg),
        .cur        (time_reg),
        .nxt        (time_next)
    );

    assign scan_next = (op_reg == tcss_pkg::OP_SCAN_TICK) ? scan_reg + 3'd1 : scan_reg;

    // Display decode uses the updated time and the pre-tick position
    tcss_disp u_disp (
        .pos             (scan_reg),
        .tm              (time_next),
        .segment_pattern (seg_next),
        .digit_select    (sel_next)
    );

    // Time and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            scan_reg <= 3'd0;
        end
        else if (advance)
        begin
            time_reg <= time_next;
            scan_reg <= scan_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            seg_reg <= seg_next;
            sel_reg <= sel_next;
            res_reg <= time_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.segment_pattern = seg_reg;
    assign rsp.digit_select    = sel_reg;
    assign rsp.field_high      = res_reg.high;
    assign rsp.field_mid       = res_reg.mid;
    assign rsp.field_low       = res_reg.low;

`ifndef SYNTHESIS
    // Stored time is always normalized
    a_time_norm: assert property (@(posedge clk) disable iff (!rst_n)
        time_reg.high < 6'd60 && time_reg.mid < 6'd60 && time_reg.low < 6'd60)
        else $error("time field out of base-60 range");

    // Digit enable is one-hot on every valid result
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot(sel_reg))
        else $error("digit select not one-hot");

    // Separator positions always show a dash
    a_dash: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (sel_reg[2] || sel_reg[5])) |->
        (seg_reg == tcss_pkg::DASH_PATTERN))
        else $error("separator digit not a dash");

    // Scan position moves only on an executed scan tick
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_reg != $past(scan_reg)) |->
        $past(advance && op_reg == tcss_pkg::OP_SCAN_TICK))
        else $error("scan moved without a scan tick");
`endif

endmodule

FILE: tb/sv/tb_time_counter_seven_segment_scan.sv
module tb_time_counter_seven_segment_scan;

    // Code 7 has no operation behind it; the block treats it as a read
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int         MINUTE_BASE = 60;
    localparam logic [7:0] DASH_SEG    = 8'h40;
    localparam int         LONG_HOLD   = 300;
    localparam int         TAIL_CYCLES = 10;

    localparam logic [7:0] DIGIT_SEG [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    localparam logic [6:0] EDGE_OPERAND [7] = '{
        7'd0, 7'd59, 7'd60, 7'd99, 7'd119, 7'd120, 7'd127
    };

    typedef struct {
        logic [2:0] op;
        logic [6:0] vh;
        logic [6:0] vl;
    } clock_req_t;

    typedef struct {
        logic [7:0] seg;
        logic [7:0] sel;
        logic [5:0] hi;
        logic [5:0] mi;
        logic [5:0] lo;
    } display_out_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tcss_req_if req_ch ();
    tcss_rsp_if rsp_ch ();

    // Testbench-side drive registers, known from time zero
    logic       drv_valid  = 1'b0;
    logic [2:0] drv_op     = '0;
    logic [6:0] drv_vh     = '0;
    logic [6:0] drv_vl     = '0;
    logic       sink_ready = 1'b0;

    assign req_ch.valid      = drv_valid;
    assign req_ch.operation  = drv_op;
    assign req_ch.value_high = drv_vh;
    assign req_ch.value_low  = drv_vl;
    assign rsp_ch.ready      = sink_ready;

    time_counter_seven_segment_scan i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // Pending requests, expected display outputs, idling knobs
    clock_req_t   pend_q [$];
    display_out_t disp_exp_q [$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_ticket = 0;
    int           hold_seen;
    int           hold_left;
    int           err_cnt = 0;

    // Shadow copy of the clock state
    logic [5:0] clk_high = '0;
    logic [5:0] clk_mid  = '0;
    logic [5:0] clk_low  = '0;
    logic [2:0] scan_pos = '0;

    // Apply one request to the shadow clock and return what the display shows
    function automatic display_out_t advance_clock(input clock_req_t r);
        display_out_t o;
        int           hi;
        int           mi;
        int           lo;
        logic [2:0]   shown;
        hi    = clk_high;
        mi    = clk_mid;
        lo    = clk_low;
        shown = scan_pos;
        case (r.op)
            tcss_pkg::OP_SEC_TICK:  lo = lo + 1;
            tcss_pkg::OP_SCAN_TICK: scan_pos = shown + 3'd1;
            tcss_pkg::OP_SET_HM:
            begin
                hi = r.vh;
                mi = r.vl;
            end
            tcss_pkg::OP_ADD_HM:
            begin
                hi = hi + r.vh;
                mi = mi + r.vl;
            end
            tcss_pkg::OP_SET_LOW:   lo = r.vh;
            tcss_pkg::OP_ADD_LOW:   lo = lo + r.vh;
            default:                ;
        endcase
        // carries may be several at once
        if (lo >= MINUTE_BASE)
        begin
            mi = mi + lo / MINUTE_BASE;
            lo = lo % MINUTE_BASE;
        end
        if (mi >= MINUTE_BASE)
        begin
            hi = hi + mi / MINUTE_BASE;
            mi = mi % MINUTE_BASE;
        end
        hi       = hi % MINUTE_BASE;
        clk_high = hi[5:0];
        clk_mid  = mi[5:0];
        clk_low  = lo[5:0];
        case (shown)
            3'd0:    o.seg = DIGIT_SEG[hi / 10];
            3'd1:    o.seg = DIGIT_SEG[hi % 10];
            3'd3:    o.seg = DIGIT_SEG[mi / 10];
            3'd4:    o.seg = DIGIT_SEG[mi % 10];
            3'd6:    o.seg = DIGIT_SEG[lo / 10];
            3'd7:    o.seg = DIGIT_SEG[lo % 10];
            default: o.seg = DASH_SEG;
        endcase
        o.sel = 8'd1 << shown;
        o.hi  = clk_high;
        o.mi  = clk_mid;
        o.lo  = clk_low;
        return o;
    endfunction

    function automatic logic [6:0] random_operand();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return 7'($urandom_range(59));
        else if (pick < 75)
            return 7'($urandom_range(127));
        else
            return EDGE_OPERAND[$urandom_range(6)];
    endfunction

    // Mostly ticks, a steady share of commands, a little unused code
    function automatic clock_req_t random_req();
        clock_req_t r;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 30)
            r.op = tcss_pkg::OP_SEC_TICK;
        else if (pick < 55)
            r.op = tcss_pkg::OP_SCAN_TICK;
        else if (pick < 64)
            r.op = tcss_pkg::OP_SET_HM;
        else if (pick < 73)
            r.op = tcss_pkg::OP_ADD_HM;
        else if (pick < 81)
            r.op = tcss_pkg::OP_SET_LOW;
        else if (pick < 89)
            r.op = tcss_pkg::OP_ADD_LOW;
        else if (pick < 96)
            r.op = tcss_pkg::OP_READ;
        else
            r.op = OP_UNUSED;
        r.vh = random_operand();
        r.vl = random_operand();
        return r;
    endfunction

    task automatic push_req(input logic [2:0] op, input logic [6:0] vh,
                            input logic [6:0] vl);
        clock_req_t r;
        r.op = op;
        r.vh = vh;
        r.vl = vl;
        pend_q.push_back(r);
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || drv_valid || disp_exp_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            pend_q.push_back(random_req());
        wait_drained();
    endtask

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            err_cnt++;
        end
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        clock_req_t r;
        if (!rst_n)
            drv_valid <= 1'b0;
        else if (!drv_valid || req_ch.ready)
        begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                r = pend_q.pop_front();
                drv_valid <= 1'b1;
                drv_op    <= r.op;
                drv_vh    <= r.vh;
                drv_vl    <= r.vl;
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, started by a new ticket
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_ticket)
        begin
            hold_left <= LONG_HOLD;
            hold_seen <= hold_ticket;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result ready with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sink_ready <= 1'b0;
        else if (hold_left != 0)
            sink_ready <= 1'b0;
        else
            sink_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check results first, then predict the request taken at this edge
    always @(posedge clk)
    begin : score_blk
        display_out_t e;
        clock_req_t   r;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (disp_exp_q.size() == 0)
                begin
                    $error("result with no request waiting");
                    err_cnt++;
                end
                else
                begin
                    e = disp_exp_q.pop_front();
                    check_field("segment_pattern", e.seg, rsp_ch.segment_pattern);
                    check_field("digit_select", e.sel, rsp_ch.digit_select);
                    check_field("field_high", e.hi, rsp_ch.field_high);
                    check_field("field_mid", e.mi, rsp_ch.field_mid);
                    check_field("field_low", e.lo, rsp_ch.field_low);
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                r.op = req_ch.operation;
                r.vh = req_ch.value_high;
                r.vl = req_ch.value_low;
                disp_exp_q.push_back(advance_clock(r));
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every operation, carries and full wrap
        push_req(tcss_pkg::OP_READ,      7'd0,   7'd0);
        push_req(tcss_pkg::OP_SEC_TICK,  7'd127, 7'd127);
        push_req(tcss_pkg::OP_SET_HM,    7'd0,   7'd0);
        push_req(tcss_pkg::OP_SET_HM,    7'd99,  7'd99);
        push_req(tcss_pkg::OP_SET_HM,    7'd127, 7'd127);
        push_req(tcss_pkg::OP_ADD_HM,    7'd127, 7'd127);
        push_req(tcss_pkg::OP_SET_LOW,   7'd127, 7'd0);
        push_req(tcss_pkg::OP_ADD_LOW,   7'd127, 7'd127);
        push_req(tcss_pkg::OP_SET_LOW,   7'd0,   7'd127);
        push_req(OP_UNUSED,              7'd127, 7'd127);
        push_req(tcss_pkg::OP_SET_HM,    7'd59,  7'd59);
        push_req(tcss_pkg::OP_SET_LOW,   7'd59,  7'd0);
        push_req(tcss_pkg::OP_SEC_TICK,  7'd0,   7'd0);
        push_req(tcss_pkg::OP_SET_HM,    7'd12,  7'd34);
        push_req(tcss_pkg::OP_SET_LOW,   7'd56,  7'd0);
        // walk the scan through all positions and wrap
        for (int i = 0; i < 9; i++)
            push_req(tcss_pkg::OP_SCAN_TICK, 7'd0, 7'd0);
        wait_drained();

        run_phase(0, 0, 170);
        run_phase(69, 0, 170);
        run_phase(0, 69, 170);
        run_phase(30, 30, 170);

        // Receiver holds off while the sender keeps offering
        hold_ticket = hold_ticket + 1;
        run_phase(0, 0, 170);

        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_cnt == 0 && disp_exp_q.size() == 0)
            $display("time_counter_seven_segment_scan: match");
        else
            $display("time_counter_seven_segment_scan: mismatch");
        $finish;
    end

    // Run limit
    initial
    begin
        #400000;
        $display("time_counter_seven_segment_scan: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
src/tcss_pkg.sv
src/tcss_if.sv
src/tcss_norm.sv
src/tcss_disp.sv
src/time_counter_seven_segment_scan.sv
tb/sv/tb_time_counter_seven_segment_scan.sv
